>>> hw/rtl/threshold_duty_ramp_core_macros.svh
// Assertion macros for the threshold duty ramp core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef THRESHOLD_DUTY_RAMP_CORE_MACROS_SVH
`define THRESHOLD_DUTY_RAMP_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TDR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/tdr_pkg.sv
// Shared types and constants for the threshold duty ramp core.
// Used by tdr_div and threshold_duty_ramp_core; no dependencies of its own.
package tdr_pkg;

   // Field and register widths.
   localparam int DIV_W      = 16;
   localparam int DUTY_W     = 14;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Duty levels in hundredths of a percent.
   localparam logic [DUTY_W-1:0] DUTY_OFF  = 14'd0;
   localparam logic [DUTY_W-1:0] DUTY_MID  = 14'd7500;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

   // Register reset values.
   localparam logic [15:0]       LOW_THR_RST   = 16'd400;
   localparam logic [15:0]       HIGH_THR_RST  = 16'd1000;
   localparam logic [DUTY_W-1:0] STEP_RST      = 14'd500;
   localparam logic [15:0]       RAMP_TIME_RST = 16'd2000;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THR   = 2'd0,
      CSR_HIGH_THR  = 2'd1,
      CSR_STEP      = 2'd2,
      CSR_RAMP_TIME = 2'd3
   } csr_idx_type;

   // Item kinds carried in tuser.
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_DIV_GAP,
      ST_DIV_TIME,
      ST_APPLY,
      ST_TICK,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/tdr_div.sv
// Serial restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on tdr_pkg for the operand width.
module tdr_div
   import tdr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   rem_shift;
   logic [DIV_W:0]   rem_diff;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign rem_shift = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_W);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_diff;
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/threshold_duty_ramp_core.sv
// Top level of the threshold duty ramp core: sequencer, duty state and registers.
// Depends on tdr_pkg, tdr_div and threshold_duty_ramp_core_macros.svh.
//
//   Channel  Direction  Transfer when          Contents
//   req_     in         req_tvalid&req_tready  tuser: cmd; tdata: sensor_value
//   rsp_     out        rsp_tvalid&rsp_tready  tdata: duty, duty_written, ramping
//   csr_     in         csr_we                 csr_index selects, csr_wdata value
//
// A tick passes through the tick and emit states into the output register; a sample that
// starts a ramp also makes two passes through the serial divider before the emit state.
// The core takes one item at a time: req_tready is high only in the idle state.
// A result waits in the output register until taken; a new item may be taken meanwhile.
// Reset is synchronous and restores the control registers, the sequencer and the duty state.
`include "threshold_duty_ramp_core_macros.svh"

module threshold_duty_ramp_core
   import tdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sensor_value
   input  logic                  req_tuser,   // [0] cmd
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [13:0] duty, [14] duty_written, [15] ramping
   // Register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Registers.
   logic [15:0]       low_thr_ff, high_thr_ff, ramp_time_ff;
   logic [DUTY_W-1:0] step_ff;

   // Sequencer and item holding.
   state_type             state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;

   // Duty state.
   logic [DUTY_W-1:0] current_duty_ff, current_duty_in;
   logic [DUTY_W-1:0] target_duty_ff, target_duty_in;
   logic              ramp_active_ff, ramp_active_in;
   logic              step_down_ff, step_down_in;
   logic [15:0]       delay_reload_ff, delay_reload_in;
   logic [15:0]       delay_left_ff, delay_left_in;
   logic [DUTY_W-1:0] gap_ff, gap_in;
   logic              written_ff, written_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   // Divider hookup.
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend, div_divisor, div_quotient;
   logic              div_done;

   // Combinational helpers.
   logic [DUTY_W-1:0] new_target;
   logic [DUTY_W-1:0] live_gap, new_gap;
   logic [DUTY_W:0]   step_sum;
   logic [DUTY_W-1:0] stepped_duty;
   logic [15:0]       delay_dec;
   logic              sample_ok;
   logic              out_free;

   tdr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff   <= LOW_THR_RST;
         high_thr_ff  <= HIGH_THR_RST;
         step_ff      <= STEP_RST;
         ramp_time_ff <= RAMP_TIME_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_LOW_THR:   low_thr_ff   <= csr_wdata;
            CSR_HIGH_THR:  high_thr_ff  <= csr_wdata;
            CSR_STEP:      step_ff      <= csr_wdata[DUTY_W-1:0];
            CSR_RAMP_TIME: ramp_time_ff <= csr_wdata;
            default:       low_thr_ff   <= low_thr_ff;
         endcase
      end
   end

   // Target lookup from the thresholds and gap towards it.
   always_comb begin
      if (sample_ff < low_thr_ff) begin
         new_target = DUTY_OFF;
      end else if (sample_ff < high_thr_ff) begin
         new_target = DUTY_MID;
      end else begin
         new_target = DUTY_FULL;
      end
      new_gap  = (new_target > current_duty_ff) ? new_target - current_duty_ff
                                                : current_duty_ff - new_target;
      live_gap = (target_duty_ff > current_duty_ff) ? target_duty_ff - current_duty_ff
                                                    : current_duty_ff - target_duty_ff;
   end

   // One ramp step in the kept direction, clamped to the duty range.
   always_comb begin
      step_sum = {1'b0, current_duty_ff} + {1'b0, step_ff};
      if (step_down_ff) begin
         stepped_duty = (current_duty_ff > step_ff) ? current_duty_ff - step_ff : DUTY_OFF;
      end else begin
         stepped_duty = (step_sum > {1'b0, DUTY_FULL}) ? DUTY_FULL : step_sum[DUTY_W-1:0];
      end
   end

   assign delay_dec = (delay_left_ff != 16'd0) ? delay_left_ff - 16'd1 : 16'd0;
   assign sample_ok = !ramp_active_ff && (step_ff != '0) && (step_ff <= DUTY_FULL);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer: next state, duty state updates and divider control.
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      sample_in       = sample_ff;
      current_duty_in = current_duty_ff;
      target_duty_in  = target_duty_ff;
      ramp_active_in  = ramp_active_ff;
      step_down_in    = step_down_ff;
      delay_reload_in = delay_reload_ff;
      delay_left_in   = delay_left_ff;
      gap_in          = gap_ff;
      written_in      = written_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      div_start       = 1'b0;
      div_dividend    = {{(DIV_W-DUTY_W){1'b0}}, gap_ff};
      div_divisor     = {{(DIV_W-DUTY_W){1'b0}}, step_ff};
      req_tready      = (state_ff == ST_IDLE);

      // A waiting result leaves when the downstream side takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_tuser;
               sample_in = req_tdata;
               state_in  = (cmd_type'(req_tuser) == CMD_TICK) ? ST_TICK : ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            if (sample_ok) begin
               target_duty_in = new_target;
               step_down_in   = (new_target <= current_duty_ff);
               gap_in         = new_gap;
               written_in     = 1'b1;
               div_start      = 1'b1;
               div_dividend   = {{(DIV_W-DUTY_W){1'b0}}, new_gap};
               state_in       = ST_DIV_GAP;
            end else begin
               written_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_DIV_GAP: begin
            // Step count ready: divide the ramp time by it, or use one tick.
            if (div_done) begin
               if (div_quotient == '0) begin
                  delay_reload_in = 16'd1;
                  state_in        = ST_APPLY;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = ramp_time_ff;
                  div_divisor  = div_quotient;
                  state_in     = ST_DIV_TIME;
               end
            end
         end
         ST_DIV_TIME: begin
            if (div_done) begin
               delay_reload_in = (div_quotient == '0) ? 16'd1 : div_quotient;
               state_in        = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // First step at once, or the exact target when within one step.
            if (gap_ff > step_ff) begin
               current_duty_in = stepped_duty;
               ramp_active_in  = 1'b1;
               delay_left_in   = delay_reload_ff;
            end else begin
               current_duty_in = target_duty_ff;
            end
            state_in = ST_EMIT;
         end
         ST_TICK: begin
            written_in = 1'b0;
            if (ramp_active_ff) begin
               delay_left_in = delay_dec;
               if (delay_dec == 16'd0) begin
                  written_in = 1'b1;
                  if (live_gap > step_ff) begin
                     current_duty_in = stepped_duty;
                     delay_left_in   = delay_reload_ff;
                  end else begin
                     current_duty_in = target_duty_ff;
                     ramp_active_in  = 1'b0;
                  end
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ramp_active_ff, written_ff, current_duty_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and duty state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         current_duty_ff <= DUTY_OFF;
         target_duty_ff  <= DUTY_OFF;
         ramp_active_ff  <= 1'b0;
         step_down_ff    <= 1'b0;
         delay_reload_ff <= 16'd1;
         delay_left_ff   <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         current_duty_ff <= current_duty_in;
         target_duty_ff  <= target_duty_in;
         ramp_active_ff  <= ramp_active_in;
         step_down_ff    <= step_down_in;
         delay_reload_ff <= delay_reload_in;
         delay_left_ff   <= delay_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sample_ff   <= sample_in;
      gap_ff      <= gap_in;
      written_ff  <= written_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The kept duty never leaves its range.
   `TDR_ASSERT_NOW(a_duty_range, clock, reset, 1'b1, current_duty_ff <= DUTY_FULL)
   // Divider results only arrive while the sequencer waits for them.
   `TDR_ASSERT_NOW(a_div_done_state, clock, reset, div_done,
                   (state_ff == ST_DIV_GAP) || (state_ff == ST_DIV_TIME))
   // An accepted item takes the sequencer out of idle.
   `TDR_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready,
                    state_ff != ST_IDLE)
   // A new result is only loaded from the emit state.
   `TDR_ASSERT_NEXT(a_emit_source, clock, reset, (state_ff != ST_EMIT) && !rsp_valid_ff,
                    !rsp_valid_ff)
   // A tick item is routed to the tick state.
   `TDR_ASSERT_NEXT(a_tick_route, clock, reset,
                    req_tvalid && req_tready && (cmd_type'(req_tuser) == CMD_TICK),
                    state_ff == ST_TICK && cmd_ff == CMD_TICK)

endmodule

>>> test/threshold_duty_ramp_core_test.sv
// Self-checking testbench for threshold_duty_ramp_core: drives samples and ticks
// into the block, predicts every duty result and checks each one as it is transferred.
// Depends on tdr_pkg and the RTL of the block alone.
module threshold_duty_ramp_core_test;
   import tdr_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 155;
   localparam int PHASE_COUNT  = 12;

   // Tracks the duty state of the block and holds the results still to come.
   class duty_ramp_scoreboard;
      typedef struct packed {
         logic              ramping;
         logic              written;
         logic [DUTY_W-1:0] duty;
      } duty_result_type;

      logic [15:0]       low_thr;
      logic [15:0]       high_thr;
      logic [DUTY_W-1:0] step;
      logic [15:0]       ramp_time;
      logic [DUTY_W-1:0] duty;
      logic [DUTY_W-1:0] target;
      bit                active;
      bit                down;
      logic [15:0]       reload;
      logic [15:0]       left;
      duty_result_type   expected_duty_q[$];
      int                errors;

      function new();
         low_thr   = LOW_THR_RST;
         high_thr  = HIGH_THR_RST;
         step      = STEP_RST;
         ramp_time = RAMP_TIME_RST;
         duty      = DUTY_OFF;
         target    = DUTY_OFF;
         active    = 1'b0;
         down      = 1'b0;
         reload    = 16'd1;
         left      = 16'd0;
         errors    = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [15:0] value);
         case (idx)
            CSR_LOW_THR:   low_thr   = value;
            CSR_HIGH_THR:  high_thr  = value;
            CSR_STEP:      step      = value[DUTY_W-1:0];
            CSR_RAMP_TIME: ramp_time = value;
            default: ;
         endcase
      endfunction

      function int unsigned gap();
         return (duty > target) ? int'(duty) - int'(target) : int'(target) - int'(duty);
      endfunction

      // One step toward the target, held inside the duty range.
      function void take_step();
         int unsigned raised;
         if (down) begin
            duty = (duty > step) ? duty - step : DUTY_OFF;
         end else begin
            raised = int'(duty) + int'(step);
            if (raised > int'(DUTY_FULL)) raised = int'(DUTY_FULL);
            duty = raised[DUTY_W-1:0];
         end
      endfunction

      // Works out the result of one accepted input transfer.
      function void note_request(cmd_type cmd, logic [15:0] sample);
         duty_result_type res;
         int unsigned     diff;
         int unsigned     steps;
         int unsigned     delay;
         bit              written;
         written = 1'b0;
         if (cmd == CMD_SAMPLE) begin
            if (!active && step != 0 && step <= DUTY_FULL) begin
               if (sample < low_thr) target = DUTY_OFF;
               else if (sample < high_thr) target = DUTY_MID;
               else target = DUTY_FULL;
               down  = (target <= duty);
               diff  = gap();
               steps = diff / int'(step);
               delay = (steps > 0) ? int'(ramp_time) / steps : 0;
               if (delay < 1) delay = 1;
               reload  = delay[15:0];
               written = 1'b1;
               if (diff > int'(step)) begin
                  take_step();
                  active = 1'b1;
                  left   = reload;
               end else begin
                  duty = target;
               end
            end
         end else if (active) begin
            if (left > 0) left--;
            if (left == 0) begin
               written = 1'b1;
               if (gap() > int'(step)) begin
                  take_step();
                  left = reload;
               end else begin
                  duty   = target;
                  active = 1'b0;
               end
            end
         end
         res.duty    = duty;
         res.written = written;
         res.ramping = active;
         expected_duty_q.push_back(res);
      endfunction

      // Compares one result transfer with the oldest prediction.
      function void check_result(logic [15:0] data);
         duty_result_type got;
         duty_result_type want;
         got = data;
         if (expected_duty_q.size() == 0) begin
            $display("%0t: result with none expected, got duty %0d written %0b ramping %0b",
                     $time, got.duty, got.written, got.ramping);
            errors++;
         end else begin
            want = expected_duty_q.pop_front();
            if (got.duty !== want.duty) begin
               $display("%0t: duty expected %0d, got %0d", $time, want.duty, got.duty);
               errors++;
            end
            if (got.written !== want.written) begin
               $display("%0t: duty_written expected %0b, got %0b",
                        $time, want.written, got.written);
               errors++;
            end
            if (got.ramping !== want.ramping) begin
               $display("%0t: ramping expected %0b, got %0b",
                        $time, want.ramping, got.ramping);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_duty_q.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   duty_ramp_scoreboard board = new();
   int          send_idle_pct = 14;
   int          recv_idle_pct = 56;
   bit          hold_request  = 1'b0;
   int          quiet_cycles  = 0;
   logic [15:0] cur_low;
   logic [15:0] cur_high;

   threshold_duty_ramp_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: random back-pressure, and one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Result checking and the watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offers one item after a random gap and waits for its transfer.
   task automatic send_item(input cmd_type cmd, input logic [15:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, value);
      @(negedge clock);
   endtask

   // Writes all four registers on consecutive cycles.
   task automatic apply_settings(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] st, input logic [15:0] rt);
      logic [15:0] vals[4];
      vals[0] = lo;
      vals[1] = hi;
      vals[2] = st;
      vals[3] = rt;
      cur_low  = lo;
      cur_high = hi;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         board.write_reg(csr_idx_type'(i), vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic wait_for_results(input int settle);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Samples cluster on the threshold edges and the ends of the range.
   function automatic logic [15:0] pick_sensor();
      case ($urandom_range(0, 6))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return cur_low - 16'd1;
         3: return cur_low;
         4: return cur_high - 16'd1;
         5: return cur_high;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // One register setting followed by a run of mostly ticks with samples between.
   task automatic run_phase(input int k, input int n);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] st;
      logic [15:0] rt;
      lo = 16'($urandom_range(200, 3000));
      hi = lo + 16'($urandom_range(0, 3000));
      st = 16'($urandom_range(1000, 5000));
      rt = 16'($urandom_range(0, 30));
      case (k)
         1: begin
            lo = 16'd0;
            hi = 16'd0;
            st = 16'd10000;
            rt = 16'hFFFF;
         end
         2: begin
            lo = 16'hFFFF;
            hi = 16'hFFFF;
            st = 16'd2500;
            rt = 16'd0;
         end
         3: begin
            st = 16'd1;
            rt = 16'hFFFF;
         end
         4: st = 16'd0;
         5: st = 16'hFFFF;
         6: begin
            lo = 16'd5000;
            hi = 16'd100;
         end
         7: begin
            st = 16'hC000 | 16'd10001;
            rt = 16'd10;
         end
         9:  st = 16'h8000 | 16'd2000;
         10: begin
            st = 16'd10000;
            rt = 16'd0;
         end
         11: st = 16'($urandom_range(1, 10000));
         default: ;
      endcase
      apply_settings(lo, hi, st, rt);
      // The receiver stops for a long stretch so that the block backs up.
      if (k == 2) hold_request = 1'b1;
      repeat (n) begin
         if ($urandom_range(0, 99) < 22) send_item(CMD_SAMPLE, pick_sensor());
         else send_item(CMD_TICK, 16'($urandom_range(0, 65535)));
      end
      wait_for_results(6);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: idle tick, each threshold edge, a ramp up and a ramp down.
      apply_settings(16'd400, 16'd1000, 16'd2500, 16'd3);
      send_item(CMD_TICK, 16'hFFFF);
      send_item(CMD_SAMPLE, 16'd0);
      send_item(CMD_SAMPLE, 16'hFFFF);
      // A sample in the middle of a ramp is dropped.
      send_item(CMD_SAMPLE, 16'd0);
      repeat (3) send_item(CMD_TICK, 16'd0);
      send_item(CMD_SAMPLE, 16'd1000);
      // The gap to the middle level fits in one step, so it is written at once.
      send_item(CMD_SAMPLE, 16'd999);
      send_item(CMD_SAMPLE, 16'd400);
      send_item(CMD_SAMPLE, 16'd399);
      repeat (2) send_item(CMD_TICK, 16'h5555);
      wait_for_results(6);
      // A zero step, and a step beyond full scale, both leave samples unused.
      apply_settings(16'd400, 16'd1000, 16'd0, 16'd3);
      send_item(CMD_SAMPLE, 16'hFFFF);
      wait_for_results(6);
      apply_settings(16'd400, 16'd1000, 16'hFFFF, 16'd3);
      send_item(CMD_SAMPLE, 16'hFFFF);
      send_item(CMD_TICK, 16'hAAAA);
      wait_for_results(6);

      // Random part over three idling modes.
      for (int k = 0; k < PHASE_COUNT; k++) begin
         if (k < 4) begin
            send_idle_pct = 14;
            recv_idle_pct = 56;
         end else if (k < 8) begin
            send_idle_pct = 56;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_phase(k, PHASE_ITEMS);
      end

      wait_for_results(50);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
